// ===== rtl/gtps_pkg.sv =====
package gtps_pkg;

  localparam int unsigned AtanMax = 24;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_SPEED = 3'd2,
    ACT_FWD   = 3'd3,
    ACT_BWD   = 3'd4,
    ACT_TURN0 = 3'd5,
    ACT_TURN1 = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    REG_ARRIVE = 3'd0,
    REG_TURN_THR = 3'd1,
    REG_FAR_THR = 3'd2,
    REG_NEAR_THR = 3'd3,
    REG_CHANGE_DIST = 3'd4,
    REG_SPEED_FAST = 3'd5,
    REG_SPEED_SLOW = 3'd6
  } reg_idx_e;

  localparam logic [7:0] CodeStop = 8'd0;
  localparam logic [7:0] CodeMax = 8'd4;
  localparam logic [15:0] PiSixth = 16'd5461;
  localparam logic [34:0] FarDist2 = 35'd122500;
  localparam logic [9:0] SpeedBias = 10'd250;
  // divide by 20 as multiply by 205 then shift by 12, exact up to 599
  localparam logic [7:0] SpeedRecip = 8'd205;
  localparam int unsigned SpeedShift = 12;
  localparam logic [7:0] SpeedMax = 8'd30;
  localparam logic [6:0] GrowRadius = 7'd50;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] d);
    logic [16:0] m;
    begin
      m = d[15] ? 17'(-$signed({d[15], d})) : {1'b0, d};
      return m[15:0] | {m[16], 15'd0};
    end
  endfunction

endpackage

// ===== rtl/go_to_point_steering.sv =====
// path: manual word, skipped tick and reported-at-goal word go straight to the output register;
// arrival after the shared-multiplier squares, other navigation words after the vectoring cordic
// loop (steps capped at 24) with the square root running alongside
// throughput: one word at a time, in_stall_o high while a word is in work, next word
// taken the cycle after the result is taken
// reset: asynchronous active low, config registers to defaults, state flags cleared, datapath not reset
module go_to_point_steering #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  manual_code_i,
  input  logic [7:0]  manual_speed_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [15:0] drift_x_i,
  input  logic signed [15:0] drift_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] final_heading_i,
  input  logic        offset_ready_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  speed_o,
  output logic        at_target_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import gtps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_SQR = 5'b00100,
    S_RUN = 5'b01000, S_OUT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] arrive_q, chg_q;
  logic [14:0] tthr_q, fthr_q, nthr_q;
  logic [7:0] sfast_q, sslow_q, prev_q;
  logic turning_q, arrived_q;
  logic [2:0] act_q;
  logic [7:0] spd_q;
  logic at_q;
  logic signed [17:0] vx_q, vy_q;
  logic signed [15:0] hd_q;
  logic [34:0] d2_q, rad2_q, tc2_q;
  logic [1:0] mstep_q;
  logic sq_done, cd_done, sq_got_q, cd_got_q;
  logic [8:0] root;
  logic signed [15:0] bear;
  logic [15:0] bear_q;
  logic [8:0] root_q;
  logic accept, cd_start, sq_start;
  logic signed [17:0] mul_a;
  logic [17:0] mul_m;
  logic [35:0] prod;

  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_o;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_o && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign action_o = act_q;
  assign speed_o = spd_q;
  assign at_target_o = at_q;

  // shared multiplier, one square a cycle
  always_comb begin
    case (mstep_q)
      2'd0: mul_a = vx_q;
      2'd1: mul_a = vy_q;
      2'd2: mul_a = 18'($signed({1'b0, arrive_q})) + (arrived_q ? 18'(GrowRadius) : 18'sd0);
      default: mul_a = 18'($signed({1'b0, chg_q}));
    endcase
    mul_m = mul_a[17] ? 18'(-mul_a) : 18'(mul_a);
    prod = 36'(mul_m) * 36'(mul_m);
  end

  assign cd_start = (state_q == S_SQR);
  assign sq_start = (state_q == S_SQR);

  gtps_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cd_start), .vx_i(vx_q), .vy_i(vy_q),
    .done_o(cd_done), .angle_o(bear)
  );

  gtps_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start),
    .v_i(d2_q >= FarDist2 ? 17'd0 : d2_q[16:0]), .done_o(sq_done), .root_o(root)
  );

  logic signed [15:0] d1, d2, da;
  logic [15:0] m1, m2, ma, thr;
  logic [9:0] sp_sum;
  logic [17:0] sp_prod;
  logic [7:0] sp_calc;
  logic [7:0] mcode, mspd;

  always_comb begin
    da = heading_i - final_heading_i;
    ma = mag16(da);
    d1 = hd_q - $signed(bear_q);
    d2 = hd_q - 16'sh8000 - $signed(bear_q);
    m1 = mag16(d1);
    m2 = mag16(d2);
    thr = turning_q ? {1'b0, tthr_q} : (d2_q > tc2_q ? {1'b0, fthr_q} : {1'b0, nthr_q});
    sp_sum = 10'(root_q) + SpeedBias;
    sp_prod = 18'(sp_sum) * 18'(SpeedRecip);
    sp_calc = (d2_q >= FarDist2) ? SpeedMax : 8'(sp_prod >> SpeedShift);
    if (sp_calc > SpeedMax) sp_calc = SpeedMax;
    mspd = manual_speed_i;
    mcode = (mspd == 8'd0) ? CodeStop : manual_code_i;
    if (mcode == CodeStop) mspd = 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      arrive_q <= 16'd100; tthr_q <= 15'd1820; fthr_q <= 15'd3641;
      nthr_q <= 15'd1820; chg_q <= 16'd500; sfast_q <= 8'd20; sslow_q <= 8'd10;
      prev_q <= '0; turning_q <= 1'b0; arrived_q <= 1'b0;
      mstep_q <= '0; sq_got_q <= 1'b0; cd_got_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ARRIVE: arrive_q <= cfg_data_i;
          REG_TURN_THR: tthr_q <= cfg_data_i[14:0];
          REG_FAR_THR: fthr_q <= cfg_data_i[14:0];
          REG_NEAR_THR: nthr_q <= cfg_data_i[14:0];
          REG_CHANGE_DIST: chg_q <= cfg_data_i;
          REG_SPEED_FAST: sfast_q <= cfg_data_i[7:0];
          REG_SPEED_SLOW: sslow_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!command_i) begin
              prev_q <= mcode;
              state_q <= S_OUT;
            end else if (final_heading_i != 16'sd0 && !offset_ready_i) begin
              state_q <= S_OUT;
            end else if (pos_x_i == goal_x_i && pos_y_i == goal_y_i) begin
              state_q <= S_OUT;
            end else begin
              mstep_q <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd3) begin
            if (d2_q < rad2_q) begin
              arrived_q <= 1'b1;
              state_q <= S_OUT;
            end else begin
              arrived_q <= 1'b0;
              sq_got_q <= 1'b0; cd_got_q <= 1'b0;
              state_q <= S_SQR;
            end
          end
        end
        S_SQR: state_q <= S_RUN;
        S_RUN: begin
          if (sq_done) sq_got_q <= 1'b1;
          if (cd_done) cd_got_q <= 1'b1;
          if (sq_got_q && cd_got_q) begin
            state_q <= S_OUT;
            if ((m1 <= m2 ? m1 : m2) > thr) turning_q <= 1'b1;
            else turning_q <= 1'b0;
          end
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_done) root_q <= root;
    if (cd_done) bear_q <= bear;
    case (state_q)
      S_IDLE: begin
        vx_q <= 18'(goal_x_i) - 18'(pos_x_i) - 18'(drift_x_i);
        vy_q <= 18'(goal_y_i) - 18'(pos_y_i) - 18'(drift_y_i);
        hd_q <= heading_i;
        act_q <= ACT_NONE; spd_q <= '0; at_q <= 1'b0;
        if (!command_i) begin
          if (mcode == prev_q) begin
            act_q <= ACT_SPEED; spd_q <= mspd;
          end else if (mcode <= CodeMax) begin
            act_q <= (mcode == CodeStop) ? ACT_STOP : action_e'(3'(mcode) + 3'd2);
            spd_q <= mspd;
          end
        end else if (final_heading_i != 16'sd0 && !offset_ready_i) begin
        end else if (pos_x_i == goal_x_i && pos_y_i == goal_y_i) begin
          act_q <= ACT_STOP; at_q <= 1'b1;
        end else begin
          // arrival result prepared early
          at_q <= 1'b1;
          if (ma > {1'b0, tthr_q}) begin
            act_q <= (da > 0) ? ACT_TURN1 : ACT_TURN0;
            spd_q <= (ma > PiSixth) ? sfast_q : sslow_q;
          end else begin
            act_q <= ACT_STOP;
          end
        end
      end
      S_MUL: begin
        case (mstep_q)
          2'd0: d2_q <= prod[34:0];
          2'd1: d2_q <= d2_q + prod[34:0];
          2'd2: rad2_q <= prod[34:0];
          default: tc2_q <= prod[34:0];
        endcase
      end
      S_RUN: begin
        if (sq_got_q && cd_got_q) begin
          at_q <= 1'b0;
          if (m1 <= m2) begin
            if (m1 > thr) begin
              act_q <= (d1 > 0) ? ACT_TURN1 : ACT_TURN0;
              spd_q <= (m1 > PiSixth) ? sfast_q : sslow_q;
            end else begin
              act_q <= ACT_FWD; spd_q <= sp_calc;
            end
          end else begin
            if (m2 > thr) begin
              act_q <= (d2 > 0) ? ACT_TURN1 : ACT_TURN0;
              spd_q <= (m2 > PiSixth) ? sfast_q : sslow_q;
            end else begin
              act_q <= ACT_BWD; spd_q <= sp_calc;
            end
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/gtps_cordic.sv =====
module gtps_cordic #(
  parameter int unsigned Steps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [17:0] vx_i,
  input  logic signed [17:0] vy_i,
  output logic               done_o,
  output logic signed [15:0] angle_o
);
  import gtps_pkg::*;

  localparam int unsigned NSteps = (Steps < AtanMax) ? Steps : AtanMax;
  localparam int unsigned CntW = $clog2(NSteps + 1);

  logic signed [37:0] x_q, x_d, y_q, y_d;
  logic [31:0] ang_q, ang_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, zero_q, zero_d;
  logic signed [37:0] xs, ys;
  logic [31:0] rnd;

  always_comb begin
    x_d = x_q; y_d = y_q; ang_d = ang_q; cnt_d = cnt_q; busy_d = busy_q;
    zero_d = zero_q;
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    done_o = 1'b0;
    if (start_i) begin
      zero_d = (vx_i == 18'sd0) && (vy_i == 18'sd0);
      if (vx_i < 0) begin
        x_d = -(38'(vx_i) <<< 14); y_d = -(38'(vy_i) <<< 14); ang_d = 32'h80000000;
      end else begin
        x_d = 38'(vx_i) <<< 14; y_d = 38'(vy_i) <<< 14; ang_d = 32'h0;
      end
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == CntW'(NSteps)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (y_q > 0) begin
          x_d = x_q + ys; y_d = y_q - xs; ang_d = ang_q + atan_lut(5'(cnt_q));
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; ang_d = ang_q - atan_lut(5'(cnt_q));
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
    rnd = ang_q + 32'h8000;
    angle_o = zero_q ? 16'sd0 : $signed(rnd[31:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; ang_q <= ang_d; zero_q <= zero_d;
  end
endmodule

// ===== rtl/gtps_sqrt.sv =====
module gtps_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] v_i,
  output logic        done_o,
  output logic [8:0]  root_o
);
  logic [16:0] rem_q, rem_d;
  logic [8:0] root_q, root_d;
  logic [3:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [10:0] trial;
  logic [18:0] cur;

  assign root_o = root_q;

  always_comb begin
    rem_d = rem_q; root_d = root_q; cnt_d = cnt_q; busy_d = busy_q; done_o = 1'b0;
    cur = {rem_q, 2'b00};
    trial = '0;
    if (start_i) begin
      rem_d = v_i; root_d = '0; cnt_d = 4'd9; busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0; done_o = 1'b1;
      end else begin
        cur = {2'b00, rem_q} >> (2 * (cnt_q - 1'b1));
        trial = {root_q, 2'b01};
        if (cur[10:0] >= trial && cur[18:11] == '0 || cur[18:11] != '0) begin
          rem_d = rem_q - (17'(trial) << (2 * (cnt_q - 1'b1)));
          root_d = {root_q[7:0], 1'b1};
        end else begin
          root_d = {root_q[7:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d;
  end
endmodule

// ===== rtl/gtps_checker.sv =====
module gtps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [7:0] speed_o,
  input logic       cfg_ready_o
);
  import gtps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) && $stable(speed_o))
    else $error("result changed under stall");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o)
    else $error("config open while busy");
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= 3'd6)
    else $error("bad action");
  a_stop_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_STOP |-> speed_o == 8'd0)
    else $error("stop with speed");
endmodule

bind go_to_point_steering gtps_checker u_gtps_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .action_o, .speed_o, .cfg_ready_o
);
